// File: design/segint_pkg.sv
// Shared types, widths and helpers for the segment pair intersection block.
`timescale 1ns / 1ps
`default_nettype none

package segint_pkg;

  // Coordinate format
  localparam int unsigned CW        = 32;          // coordinate width
  localparam int unsigned FRAC_BITS = 16;          // fraction bits of a coordinate
  localparam int unsigned DW        = CW + 1;      // difference width
  localparam int unsigned PW        = 2 * DW;      // product width
  localparam int unsigned NW        = PW + 1;      // denominator / numerator width
  localparam int unsigned QW        = DW;          // quotient bits
  localparam int unsigned NUMW      = NW + DW;     // scaled numerator width
  localparam int unsigned TW        = 32;          // tolerance register width

  // Tolerance after reset, about 1e-6 in units of 2^-(2*FRAC_BITS)
  localparam logic [TW-1:0] TOL_RESET = TW'(4295);

  // Queue between the front and back parts
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Front pipeline stages that can hold a request
  localparam int unsigned FSTAGES = 4;
  localparam int unsigned FCW     = $clog2(FSTAGES + 1);

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_MISS     = 2'd1,
    OUT_PARALLEL = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [CW-1:0] a_start_x;
    logic [CW-1:0] a_start_y;
    logic [CW-1:0] a_end_x;
    logic [CW-1:0] a_end_y;
    logic [CW-1:0] b_start_x;
    logic [CW-1:0] b_start_y;
    logic [CW-1:0] b_end_x;
    logic [CW-1:0] b_end_y;
  } seg_req_t;

  typedef struct packed {
    logic [1:0]    outcome;
    logic [CW-1:0] cross_x;
    logic [CW-1:0] cross_y;
  } seg_res_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    outcome_e      outcome;
    logic [NW-1:0] ad;     // |denominator|
    logic [NW-1:0] tn;     // sign-corrected t numerator
    logic [CW-1:0] p0x;
    logic [CW-1:0] p0y;
    logic [DW-1:0] dax;
    logic [DW-1:0] day;
  } seg_job_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [QAW:0] count;
    logic         empty;
  } q_stat_t;

  // Signed difference of two coordinates, one bit wider
  function automatic logic [DW-1:0] sdiff(logic [CW-1:0] a, logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  // Magnitude of a signed difference
  function automatic logic [DW-1:0] mag(logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

endpackage

`default_nettype wire

// File: design/segint_front.sv
// Front part: differences, cross products, sign fix-up and classification.
`timescale 1ns / 1ps
`default_nettype none

module segint_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      accept_i,
  input  segint_pkg::seg_req_t     req_i,
  input  wire                      cfg_we_i,
  input  wire [segint_pkg::TW-1:0] cfg_wdata_i,
  output logic                     push_o,
  output segint_pkg::seg_job_t     job_o,
  output logic [segint_pkg::FCW-1:0] inflight_o
);
  import segint_pkg::*;

  logic [TW-1:0] tol_q;

  // stage 1
  logic                 v1_q;
  logic [CW-1:0]        p0x1_q, p0y1_q;
  logic [DW-1:0]        dax1_q, day1_q, dbx1_q, dby1_q, ex1_q, ey1_q;
  // stage 2
  logic                 v2_q;
  logic [CW-1:0]        p0x2_q, p0y2_q;
  logic [DW-1:0]        dax2_q, day2_q;
  logic signed [PW-1:0] m_dadb_q, m_dbda_q, m_dae_q, m_daex_q, m_dbe_q, m_dbex_q;
  // stage 3
  logic                 v3_q;
  logic [CW-1:0]        p0x3_q, p0y3_q;
  logic [DW-1:0]        dax3_q, day3_q;
  logic [NW-1:0]        d3_q, sn3_q, tn3_q;
  // stage 4
  logic                 v4_q;
  logic [CW-1:0]        p0x4_q, p0y4_q;
  logic [DW-1:0]        dax4_q, day4_q;
  logic [NW-1:0]        ad4_q, sn4_q, tn4_q;

  logic                 parallel, miss;

  // Hold the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Advance the stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Form direction vectors and start offset
  always_ff @(posedge clk_i) begin
    p0x1_q <= req_i.a_start_x;
    p0y1_q <= req_i.a_start_y;
    dax1_q <= sdiff(req_i.a_end_x, req_i.a_start_x);
    day1_q <= sdiff(req_i.a_end_y, req_i.a_start_y);
    dbx1_q <= sdiff(req_i.b_end_x, req_i.b_start_x);
    dby1_q <= sdiff(req_i.b_end_y, req_i.b_start_y);
    ex1_q  <= sdiff(req_i.a_start_x, req_i.b_start_x);
    ey1_q  <= sdiff(req_i.a_start_y, req_i.b_start_y);
  end

  // Multiply out the cross products
  always_ff @(posedge clk_i) begin
    p0x2_q   <= p0x1_q;
    p0y2_q   <= p0y1_q;
    dax2_q   <= dax1_q;
    day2_q   <= day1_q;
    m_dadb_q <= $signed(dax1_q) * $signed(dby1_q);
    m_dbda_q <= $signed(dbx1_q) * $signed(day1_q);
    m_dae_q  <= $signed(dax1_q) * $signed(ey1_q);
    m_daex_q <= $signed(day1_q) * $signed(ex1_q);
    m_dbe_q  <= $signed(dbx1_q) * $signed(ey1_q);
    m_dbex_q <= $signed(dby1_q) * $signed(ex1_q);
  end

  // Subtract into denominator and numerators
  always_ff @(posedge clk_i) begin
    p0x3_q <= p0x2_q;
    p0y3_q <= p0y2_q;
    dax3_q <= dax2_q;
    day3_q <= day2_q;
    d3_q   <= {m_dadb_q[PW-1], m_dadb_q} - {m_dbda_q[PW-1], m_dbda_q};
    sn3_q  <= {m_dae_q[PW-1], m_dae_q} - {m_daex_q[PW-1], m_daex_q};
    tn3_q  <= {m_dbe_q[PW-1], m_dbe_q} - {m_dbex_q[PW-1], m_dbex_q};
  end

  // Flip signs so the denominator is nonnegative
  always_ff @(posedge clk_i) begin
    p0x4_q <= p0x3_q;
    p0y4_q <= p0y3_q;
    dax4_q <= dax3_q;
    day4_q <= day3_q;
    ad4_q  <= d3_q[NW-1] ? (~d3_q + NW'(1))  : d3_q;
    sn4_q  <= d3_q[NW-1] ? (~sn3_q + NW'(1)) : sn3_q;
    tn4_q  <= d3_q[NW-1] ? (~tn3_q + NW'(1)) : tn3_q;
  end

  // Classify: parallel, outside [0,1], or hit
  always_comb begin
    parallel = (ad4_q == '0) || (ad4_q < {{(NW-TW){1'b0}}, tol_q});
    miss     = sn4_q[NW-1] || tn4_q[NW-1] || (ad4_q < sn4_q) || (ad4_q < tn4_q);
  end

  always_comb begin
    job_o.ad  = ad4_q;
    job_o.tn  = tn4_q;
    job_o.p0x = p0x4_q;
    job_o.p0y = p0y4_q;
    job_o.dax = dax4_q;
    job_o.day = day4_q;
    priority if (parallel) begin
      job_o.outcome = OUT_PARALLEL;
    end else if (miss) begin
      job_o.outcome = OUT_MISS;
    end else begin
      job_o.outcome = OUT_HIT;
    end
  end

  assign push_o     = v4_q;
  assign inflight_o = FCW'(v1_q) + FCW'(v2_q) + FCW'(v3_q) + FCW'(v4_q);

endmodule

`default_nettype wire

// File: design/segint_queue.sv
// Short request queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module segint_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  segint_pkg::seg_job_t  job_i,
  input  wire                   pop_i,
  output segint_pkg::seg_job_t  head_o,
  output segint_pkg::q_stat_t   stat_o
);
  import segint_pkg::*;

  seg_job_t       mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   count_q;

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QAW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QAW'(1);
      end
      count_q <= count_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// File: design/segint_back.sv
// Back part: scaled numerator, pipelined restoring divider, point assembly.
`timescale 1ns / 1ps
`default_nettype none

module segint_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pop_i,
  input  segint_pkg::seg_job_t head_i,
  output logic                 res_valid_o,
  output segint_pkg::seg_res_t res_o
);
  import segint_pkg::*;

  localparam int unsigned HW = NW - DW;  // high part of the t numerator

  // stage b1: partial products
  logic              vb1_q;
  outcome_e          oc1_q;
  logic [NW-1:0]     den1_q;
  logic [CW-1:0]     p0x1_q, p0y1_q;
  logic              nx1_q, ny1_q;
  logic [2*DW-1:0]   plx_q, ply_q;
  logic [NW-1:0]     phx_q, phy_q;
  logic [DW-1:0]     mx, my;

  // stage b2: full numerators
  logic              vb2_q;
  outcome_e          oc2_q;
  logic [NW-1:0]     den2_q;
  logic [CW-1:0]     p0x2_q, p0y2_q;
  logic              nx2_q, ny2_q;
  logic [NUMW-1:0]   numx_q, numy_q;

  // divider stages, index 0 is the entry
  logic              dv_q   [QW+1];
  outcome_e          doc_q  [QW+1];
  logic [NW-1:0]     dden_q [QW+1];
  logic [CW-1:0]     dp0x_q [QW+1];
  logic [CW-1:0]     dp0y_q [QW+1];
  logic              dnx_q  [QW+1];
  logic              dny_q  [QW+1];
  logic [NW-1:0]     rx_q   [QW+1];
  logic [NW-1:0]     ry_q   [QW+1];
  logic [QW-1:0]     lx_q   [QW+1];   // numerator bits still to shift in / quotient
  logic [QW-1:0]     ly_q   [QW+1];

  logic              res_valid_q;
  seg_res_t          res_q;
  logic [CW-1:0]     qx, qy;

  assign mx = mag(head_i.dax);
  assign my = mag(head_i.day);

  // Valid bits through the back pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q       <= 1'b0;
      vb2_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      vb1_q       <= pop_i;
      vb2_q       <= vb1_q;
      res_valid_q <= dv_q[QW];
    end
  end

  // Split t numerator times |delta| into two partial products
  always_ff @(posedge clk_i) begin
    oc1_q  <= head_i.outcome;
    den1_q <= head_i.ad;
    p0x1_q <= head_i.p0x;
    p0y1_q <= head_i.p0y;
    nx1_q  <= head_i.dax[DW-1];
    ny1_q  <= head_i.day[DW-1];
    plx_q  <= head_i.tn[DW-1:0] * mx;
    ply_q  <= head_i.tn[DW-1:0] * my;
    phx_q  <= head_i.tn[NW-1:DW] * mx;
    phy_q  <= head_i.tn[NW-1:DW] * my;
  end

  // Sum the partial products
  always_ff @(posedge clk_i) begin
    oc2_q  <= oc1_q;
    den2_q <= den1_q;
    p0x2_q <= p0x1_q;
    p0y2_q <= p0y1_q;
    nx2_q  <= nx1_q;
    ny2_q  <= ny1_q;
    numx_q <= {phx_q, {DW{1'b0}}} + {{HW{1'b0}}, plx_q};
    numy_q <= {phy_q, {DW{1'b0}}} + {{HW{1'b0}}, ply_q};
  end

  // Load the divider: top bits form the first partial remainder
  always_comb begin
    dv_q[0]   = vb2_q;
    doc_q[0]  = oc2_q;
    dden_q[0] = den2_q;
    dp0x_q[0] = p0x2_q;
    dp0y_q[0] = p0y2_q;
    dnx_q[0]  = nx2_q;
    dny_q[0]  = ny2_q;
    rx_q[0]   = numx_q[NUMW-1:QW];
    ry_q[0]   = numy_q[NUMW-1:QW];
    lx_q[0]   = numx_q[QW-1:0];
    ly_q[0]   = numy_q[QW-1:0];
  end

  // One quotient bit per stage for each coordinate
  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [NW:0] sx, sy;
    logic        gx, gy;

    always_comb begin
      sx = {rx_q[i], lx_q[i][QW-1]};
      sy = {ry_q[i], ly_q[i][QW-1]};
      gx = (sx >= {1'b0, dden_q[i]});
      gy = (sy >= {1'b0, dden_q[i]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else begin
        dv_q[i+1] <= dv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      doc_q[i+1]  <= doc_q[i];
      dden_q[i+1] <= dden_q[i];
      dp0x_q[i+1] <= dp0x_q[i];
      dp0y_q[i+1] <= dp0y_q[i];
      dnx_q[i+1]  <= dnx_q[i];
      dny_q[i+1]  <= dny_q[i];
      rx_q[i+1]   <= gx ? NW'(sx - {1'b0, dden_q[i]}) : NW'(sx);
      ry_q[i+1]   <= gy ? NW'(sy - {1'b0, dden_q[i]}) : NW'(sy);
      lx_q[i+1]   <= {lx_q[i][QW-2:0], gx};
      ly_q[i+1]   <= {ly_q[i][QW-2:0], gy};
    end
  end

  // Offset the start point by the quotient
  assign qx = lx_q[QW][CW-1:0];
  assign qy = ly_q[QW][CW-1:0];

  always_ff @(posedge clk_i) begin
    res_q.outcome <= doc_q[QW];
    if (doc_q[QW] == OUT_HIT) begin
      res_q.cross_x <= dnx_q[QW] ? (dp0x_q[QW] - qx) : (dp0x_q[QW] + qx);
      res_q.cross_y <= dny_q[QW] ? (dp0y_q[QW] - qy) : (dp0y_q[QW] + qy);
    end else begin
      res_q.cross_x <= '0;
      res_q.cross_y <= '0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: design/segment_pair_intersection_top.sv
// Top level of the segment pair intersection block.
`timescale 1ns / 1ps
`default_nettype none

// Takes one segment pair request per clock and returns one result per request,
// in order, on res_o for a single cycle flagged by res_valid_o; results cannot
// be held off. Requests pass four front stages (differences, cross products,
// denominator, sign fix-up), the request queue, two numerator stages, a
// 33-stage restoring divider retiring one quotient bit per stage, then the
// output register. busy rises only if the request queue plus the front stages
// could overflow, which does not happen because the back part drains one
// request per cycle. Write the parallel tolerance register by cfg_we_i /
// cfg_wdata_i only while no request is in flight; the block does not check.
module segment_pair_intersection_top (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  segint_pkg::seg_req_t     req_i,
  input  wire                      cfg_we_i,
  input  wire [segint_pkg::TW-1:0] cfg_wdata_i,
  output logic                     res_valid_o,
  output segint_pkg::seg_res_t     res_o
);
  import segint_pkg::*;

  logic             accept;
  logic             push;
  logic             pop;
  seg_job_t         job;
  seg_job_t         head;
  q_stat_t          qstat;
  logic [FCW-1:0]   inflight;
  logic [QAW+1:0]   load;

  // Hold off requests when the queue could not absorb the front stages
  assign load   = (QAW+2)'(qstat.count) + (QAW+2)'(inflight);
  assign busy   = (load >= (QAW+2)'(QDEPTH));
  assign accept = start && !busy;
  assign pop    = !qstat.empty;

  segint_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .job_o       (job),
    .inflight_o  (inflight)
  );

  segint_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  segint_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .head_i      (head),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
